FILE: src/qpr_pkg.sv
`timescale 1ns / 1ps

package qpr_pkg;

  typedef enum logic {
    OP_PRODUCT = 1'b0,
    OP_ROTATE  = 1'b1
  } op_t;

  // Register stages from input to output register, output register included.
  localparam int PIPE_STAGES = 5;

  // Hamilton product r[i] = sum over k of +/- a[k] * b[i ^ k].
  // HAM_NEG[i][k] set means the term is subtracted.
  localparam logic [3:0][3:0] HAM_NEG = '{
    4'b0100,  // r[3]: a2*b1 subtracted
    4'b0010,  // r[2]: a1*b3 subtracted
    4'b1000,  // r[1]: a3*b2 subtracted
    4'b1110   // r[0]: a1*b1, a2*b2, a3*b3 subtracted
  };

endpackage

FILE: src/quaternion_product_rotate.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_ready   in_operation, in_p_w..in_p_z, in_q_w..in_q_z
// out       source     out_valid / out_ready out_w, out_x, out_y, out_z
//
// Five register stages: p*q partial products, p*q sums, rotation partial
// products, rotation sums, round/saturate output register. One beat enters
// per cycle while in_ready is high; each beat passes these stages in order.
// rst_n (synchronous, active low) clears only the stage valid bits.
// Each stage advances when it is empty or the stage after it advances, so a
// stall on out_ready backs up stage by stage and bubbles are squeezed out.
module quaternion_product_rotate #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic signed [COMPONENT_WIDTH-1:0] in_p_w,
  input  logic signed [COMPONENT_WIDTH-1:0] in_p_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_p_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_p_z,
  input  logic signed [COMPONENT_WIDTH-1:0] in_q_w,
  input  logic signed [COMPONENT_WIDTH-1:0] in_q_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_q_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_q_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [COMPONENT_WIDTH-1:0] out_w,
  output logic signed [COMPONENT_WIDTH-1:0] out_x,
  output logic signed [COMPONENT_WIDTH-1:0] out_y,
  output logic signed [COMPONENT_WIDTH-1:0] out_z
);

  localparam int W    = COMPONENT_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int NS   = qpr_pkg::PIPE_STAGES;
  // Exact p*q needs 2W+2 bits; everything beyond 64 bits wraps modulo 2^64.
  localparam int PW   = 2 * W + 2;
  localparam int PQW  = (PW > 64) ? 64 : PW;
  localparam int P2W  = PQW + W + 1;
  localparam int S2W  = P2W + 2;
  localparam int RW3  = 3 * W + 3;
  localparam int ROTW = (RW3 > 64) ? 64 : RW3;

  localparam logic signed [63:0] HALF_PROD = 64'sd1 <<< (F - 1);
  localparam logic signed [63:0] HALF_ROT  = 64'sd1 <<< (2 * F - 1);
  localparam logic signed [63:0] SAT_HI    = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO    = -(64'sd1 <<< (W - 1));

  // ---------------------------------------------------------------------
  // Stage valid bits and advance chain
  // ---------------------------------------------------------------------
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = ~vld_r[NS-1] | out_ready;
    for (int s = NS - 2; s >= 0; s--) begin
      adv[s] = ~vld_r[s] | adv[s+1];
    end
    vld_nxt = vld_r;
    // Load each stage from the one above when it advances; a bubble loads as
    // not valid.
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int s = 1; s < NS; s++) begin
      if (adv[s]) begin
        vld_nxt[s] = vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NS-1];

  // ---------------------------------------------------------------------
  // Stage 1: partial products of p*q, conj(p) formed wide
  // ---------------------------------------------------------------------
  logic signed [W-1:0]   p_in [4];
  logic signed [W-1:0]   q_in [4];
  logic signed [W:0]     pext;

  qpr_pkg::op_t          op1_r,  op1_nxt;
  logic signed [W:0]     pc1_r   [4];
  logic signed [W:0]     pc1_nxt [4];
  logic signed [2*W-1:0] pp1_r   [4][4];
  logic signed [2*W-1:0] pp1_nxt [4][4];

  always_comb begin
    p_in[0] = in_p_w;
    p_in[1] = in_p_x;
    p_in[2] = in_p_y;
    p_in[3] = in_p_z;
    q_in[0] = in_q_w;
    q_in[1] = in_q_x;
    q_in[2] = in_q_y;
    q_in[3] = in_q_z;
    op1_nxt = qpr_pkg::op_t'(in_operation);
    pext    = '0;
    for (int k = 0; k < 4; k++) begin
      pext = {p_in[k][W-1], p_in[k]};
      // Negate the vector parts at W+1 bits so the most negative value survives.
      pc1_nxt[k] = (k == 0) ? pext : -pext;
    end
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        pp1_nxt[i][k] = p_in[k] * q_in[i ^ k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      op1_r <= op1_nxt;
      pc1_r <= pc1_nxt;
      pp1_r <= pp1_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: sum p*q
  // ---------------------------------------------------------------------
  qpr_pkg::op_t          op2_r;
  logic signed [W:0]     pc2_r  [4];
  logic signed [PQW-1:0] pq2_r  [4];
  logic signed [PQW-1:0] pq2_nxt [4];
  logic signed [PW-1:0]  acc1;

  always_comb begin
    acc1 = '0;
    for (int i = 0; i < 4; i++) begin
      acc1 = '0;
      for (int k = 0; k < 4; k++) begin
        if (qpr_pkg::HAM_NEG[i][k]) begin
          acc1 = acc1 - PW'(pp1_r[i][k]);
        end else begin
          acc1 = acc1 + PW'(pp1_r[i][k]);
        end
      end
      pq2_nxt[i] = acc1[PQW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      op2_r <= op1_r;
      pc2_r <= pc1_r;
      pq2_r <= pq2_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: partial products of (p*q)*conj(p)
  // ---------------------------------------------------------------------
  qpr_pkg::op_t          op3_r;
  logic signed [PQW-1:0] pq3_r   [4];
  logic signed [P2W-1:0] pp3_r   [4][4];
  logic signed [P2W-1:0] pp3_nxt [4][4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        pp3_nxt[i][k] = pq2_r[k] * pc2_r[i ^ k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      op3_r <= op2_r;
      pq3_r <= pq2_r;
      pp3_r <= pp3_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: sum the rotation
  // ---------------------------------------------------------------------
  qpr_pkg::op_t           op4_r;
  logic signed [PQW-1:0]  pq4_r   [4];
  logic signed [ROTW-1:0] rot4_r  [4];
  logic signed [ROTW-1:0] rot4_nxt [4];
  logic signed [S2W-1:0]  acc2;

  always_comb begin
    acc2 = '0;
    for (int i = 0; i < 4; i++) begin
      acc2 = '0;
      for (int k = 0; k < 4; k++) begin
        if (qpr_pkg::HAM_NEG[i][k]) begin
          acc2 = acc2 - S2W'(pp3_r[i][k]);
        end else begin
          acc2 = acc2 + S2W'(pp3_r[i][k]);
        end
      end
      rot4_nxt[i] = acc2[ROTW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      op4_r  <= op3_r;
      pq4_r  <= pq3_r;
      rot4_r <= rot4_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: round half up, saturate, output register
  // ---------------------------------------------------------------------
  logic signed [W-1:0] res5_r   [4];
  logic signed [W-1:0] res5_nxt [4];
  logic signed [63:0]  rnd;
  logic signed [63:0]  shf;

  always_comb begin
    rnd = '0;
    shf = '0;
    for (int i = 0; i < 4; i++) begin
      if (op4_r == qpr_pkg::OP_ROTATE) begin
        rnd = 64'(rot4_r[i]) + HALF_ROT;
        shf = rnd >>> (2 * F);
      end else begin
        rnd = 64'(pq4_r[i]) + HALF_PROD;
        shf = rnd >>> F;
      end
      if (shf < SAT_LO) begin
        res5_nxt[i] = SAT_LO[W-1:0];
      end else if (shf > SAT_HI) begin
        res5_nxt[i] = SAT_HI[W-1:0];
      end else begin
        res5_nxt[i] = shf[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      res5_r <= res5_nxt;
    end
  end

  assign out_w = res5_r[0];
  assign out_x = res5_r[1];
  assign out_y = res5_r[2];
  assign out_z = res5_r[3];

endmodule

FILE: src/qpr_checker.sv
`timescale 1ns / 1ps

module qpr_checker #(
  parameter int COMPONENT_WIDTH = 16
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [COMPONENT_WIDTH-1:0] out_w,
  input logic [COMPONENT_WIDTH-1:0] out_x,
  input logic [COMPONENT_WIDTH-1:0] out_y,
  input logic [COMPONENT_WIDTH-1:0] out_z
);

  // Reset empties the pipeline.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // An output that is being taken lets every stage advance.
  a_ready_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // With no backpressure an accepted beat is checked to come out at the output.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
    |=> out_valid)
    else $error("beat lost in the pipeline");

  // Hold a stalled result.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_w) && $stable(out_x)
    && $stable(out_y) && $stable(out_z))
    else $error("stalled output beat changed");

endmodule

bind quaternion_product_rotate qpr_checker #(
  .COMPONENT_WIDTH(COMPONENT_WIDTH)
) u_qpr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_w    (out_w),
  .out_x    (out_x),
  .out_y    (out_y),
  .out_z    (out_z)
);
